### rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the block sub-allocator
// Word layouts, operation and status codes, sequencer states and the
// command and status bundles that run between the top level and the cells.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAX_RECORDS = 256;
  localparam int MAX_BLOCKS  = 16;
  localparam int REC_AW      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = REC_AW + 1;
  localparam int BLK_W       = $clog2(MAX_BLOCKS);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOOK  = 2'd2;
  localparam logic [1:0] KIND_RESET = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
  localparam logic [2:0] ST_TABLE     = 3'd3;
  localparam logic [2:0] ST_BAD       = 3'd4;
  localparam logic [2:0] ST_FL_FULL   = 3'd5;

  localparam logic CFG_BLOCK_SIZE  = 1'b0;
  localparam logic CFG_BLOCK_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FRD, S_RRD, S_FCMP, S_CRD, S_CWR, S_BLK, S_BWAIT, S_LOOK
  } bsa_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] size;
    logic [31:0] alignment;
    logic [7:0]  handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  handle_out;
    logic [3:0]  block_index;
    logic [31:0] offset;
    logic [31:0] granted_size;
  } out_word_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [31:0]      off;
    logic [31:0]      size;
  } rec_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic        clr;
    logic [31:0] req;
    logic [31:0] cap;
    logic [31:0] new_fill;
  } cell_cmd_t;

  typedef struct packed {
    logic        hit;
    logic        open;
    logic [31:0] fill;
  } cell_stat_t;

endpackage

### rtl/bsa_cell.sv
// ----------------------------------------------------------------------------
// bsa_cell: one backing block
// Holds the fill level and open flag of one block and passes the search
// token on to its neighbor when it is open and the request does not fit here.
// ----------------------------------------------------------------------------
module bsa_cell import bsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       upd,
  input  logic       go_i,
  output logic       go_o,
  output cell_stat_t stat
);

  logic        tok_r;
  logic        open_r, open_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic        fits;

  assign fits = ({1'b0, fill_r} + {1'b0, cmd.req}) <= {1'b0, cmd.cap};

  // A closed cell ends the search: it is the block to open next.
  assign stat.hit  = tok_r & (~open_r | fits);
  assign stat.open = open_r;
  assign stat.fill = open_r ? fill_r : 32'd0;
  assign go_o      = tok_r & open_r & ~fits;

  always_comb begin
    open_nxt = open_r;
    fill_nxt = fill_r;
    if (cmd.clr) begin
      open_nxt = 1'b0;
    end else if (upd) begin
      open_nxt = 1'b1;
      fill_nxt = cmd.new_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      open_r <= 1'b0;
    end else begin
      tok_r  <= go_i;
      open_r <= open_nxt;
    end
    fill_r <= fill_nxt;
  end

endmodule

### rtl/block_suballocator.sv
// ----------------------------------------------------------------------------
// block_suballocator: first-fit free list plus bump allocator
// Records and free list live in memories with one read and one write port;
// blocks are a row of cells searched by a token that moves one cell per cycle.
// ----------------------------------------------------------------------------
// Free, reset-blocks and failed free or look-up decide in the idle state; look-up
// reads its record first. Allocate checks the size (too large ends there), then
// scans the free list entry by entry, then ends on a full table, moves the later
// entries up after a free-list hit, or sends the token down the block chain.
// The result strobe follows in the cycle after the decision and busy drops with it,
// so the next word is taken in the strobe cycle. rst_n clears counts and blocks.
module block_suballocator import bsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  bsa_state_t state_r, state_nxt;

  logic [31:0]      bsize_r;
  logic [4:0]       blim_r;
  logic [32:0]      al_r, al_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       h_r, h_nxt;
  logic [CNT_W-1:0] rec_count_r, rec_count_nxt;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  rec_t             rec_mem [MAX_RECORDS];
  rec_t             rec_q;
  logic [REC_AW-1:0] rec_raddr;
  logic             rec_we;
  rec_t             rec_wdata;

  logic [7:0]       fl_mem [MAX_RECORDS];
  logic [7:0]       fl_q;
  logic [REC_AW-1:0] fl_raddr, fl_waddr;
  logic             fl_we;
  logic [7:0]       fl_wdata;

  cell_cmd_t              cmd;
  logic [MAX_BLOCKS-1:0]  upd;
  logic [MAX_BLOCKS:0]    go;
  cell_stat_t             stat [MAX_BLOCKS];

  logic             hit_any, hit_open;
  logic [BLK_W-1:0] hit_k;
  logic [31:0]      hit_fill;
  logic             bwait_commit;
  logic [CNT_W-1:0] idx_inc;
  logic [32:0]      am1;

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign idx_inc   = idx_r + 1'b1;
  assign am1       = {1'b0, in_word.alignment} - 33'd1;

  // Block chain.
  assign go[0] = state_r == S_BLK;
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    bsa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .upd   (upd[k]),
      .go_i  (go[k]),
      .go_o  (go[k+1]),
      .stat  (stat[k])
    );
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_open = 1'b0;
    hit_k    = '0;
    hit_fill = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (stat[k].hit) begin
        hit_any  = 1'b1;
        hit_open = stat[k].open;
        hit_k    = BLK_W'(k);
        hit_fill = stat[k].fill;
      end
    end
  end

  // A closed cell may be opened only below the block limit.
  assign bwait_commit = hit_any & (hit_open | ({1'b0, hit_k} < blim_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_word.kind)
            KIND_ALLOC: state_nxt = S_CHECK;
            KIND_LOOK: begin
              if ({1'b0, in_word.handle} < rec_count_r) state_nxt = S_LOOK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: state_nxt = (al_r > {1'b0, bsize_r}) ? S_IDLE : S_FRD;
      S_FRD: begin
        if (idx_r < free_count_r)                      state_nxt = S_RRD;
        else if (rec_count_r == CNT_W'(MAX_RECORDS))    state_nxt = S_IDLE;
        else                                           state_nxt = S_BLK;
      end
      S_RRD:  state_nxt = S_FCMP;
      S_FCMP: state_nxt = (al_r <= {1'b0, rec_q.size}) ? S_CRD : S_FRD;
      S_CRD:  state_nxt = (idx_inc >= free_count_r) ? S_IDLE : S_CWR;
      S_CWR:  state_nxt = S_CRD;
      S_BLK:  state_nxt = S_BWAIT;
      S_BWAIT: begin
        if (hit_any || go[MAX_BLOCKS]) state_nxt = S_IDLE;
      end
      S_LOOK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    al_nxt         = al_r;
    idx_nxt        = idx_r;
    h_nxt          = h_r;
    rec_count_nxt  = rec_count_r;
    free_count_nxt = free_count_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    rec_raddr      = h_r;
    rec_we         = 1'b0;
    rec_wdata      = '{blk: hit_k, off: hit_fill, size: al_r[31:0]};
    fl_raddr       = idx_r[REC_AW-1:0];
    fl_we          = 1'b0;
    fl_waddr       = idx_r[REC_AW-1:0];
    fl_wdata       = fl_q;
    cmd.clr        = 1'b0;
    cmd.req        = al_r[31:0];
    cmd.cap        = bsize_r;
    cmd.new_fill   = hit_fill + al_r[31:0];
    upd            = '0;
    unique case (state_r)
      S_IDLE: begin
        rec_raddr = in_word.handle;
        if (start) begin
          h_nxt   = in_word.handle;
          idx_nxt = '0;
          // Round up in 33 bits; alignment zero masks everything away.
          al_nxt  = ({1'b0, in_word.size} + am1) & ~am1;
          out_nxt = '{status: ST_OK, handle_out: in_word.handle, block_index: '0,
                      offset: '0, granted_size: '0};
          unique case (in_word.kind)
            KIND_FREE: begin
              out_valid_nxt = 1'b1;
              if ({1'b0, in_word.handle} >= rec_count_r) begin
                out_nxt.status = ST_BAD;
              end else if (free_count_r == CNT_W'(MAX_RECORDS)) begin
                out_nxt.status = ST_FL_FULL;
              end else begin
                fl_we          = 1'b1;
                fl_waddr       = free_count_r[REC_AW-1:0];
                fl_wdata       = in_word.handle;
                free_count_nxt = free_count_r + 1'b1;
              end
            end
            KIND_LOOK: begin
              if ({1'b0, in_word.handle} >= rec_count_r) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_BAD;
              end
            end
            KIND_RESET: begin
              out_valid_nxt      = 1'b1;
              out_nxt.handle_out = '0;
              cmd.clr            = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        out_nxt.handle_out = '0;
        if (al_r > {1'b0, bsize_r}) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_TOO_LARGE;
        end
      end
      S_FRD: begin
        if (idx_r >= free_count_r && rec_count_r == CNT_W'(MAX_RECORDS)) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_TABLE;
        end
      end
      S_RRD: begin
        rec_raddr = fl_q;
        h_nxt     = fl_q;
      end
      S_FCMP: begin
        if (al_r <= {1'b0, rec_q.size}) begin
          out_nxt = '{status: ST_OK, handle_out: h_r, block_index: rec_q.blk,
                      offset: rec_q.off, granted_size: rec_q.size};
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_CRD: begin
        fl_raddr = idx_inc[REC_AW-1:0];
        if (idx_inc >= free_count_r) begin
          out_valid_nxt  = 1'b1;
          free_count_nxt = free_count_r - 1'b1;
        end
      end
      S_CWR: begin
        fl_we   = 1'b1;
        idx_nxt = idx_inc;
      end
      S_BWAIT: begin
        if (bwait_commit) begin
          rec_we        = 1'b1;
          upd[hit_k]    = 1'b1;
          rec_count_nxt = rec_count_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_OK, handle_out: rec_count_r[7:0], block_index: hit_k,
                      offset: hit_fill, granted_size: al_r[31:0]};
        end else if (hit_any || go[MAX_BLOCKS]) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_NO_BLOCK;
        end
      end
      S_LOOK: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{status: ST_OK, handle_out: h_r, block_index: rec_q.blk,
                    offset: rec_q.off, granted_size: rec_q.size};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_count_r[REC_AW-1:0]] <= rec_wdata;
    end
    rec_q <= rec_mem[rec_raddr];
    if (fl_we) begin
      fl_mem[fl_waddr] <= fl_wdata;
    end
    fl_q <= fl_mem[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bsize_r      <= 32'd65536;
      blim_r       <= 5'd16;
      rec_count_r  <= '0;
      free_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rec_count_r  <= rec_count_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_SIZE:  bsize_r <= cfg_wdata;
          CFG_BLOCK_LIMIT: blim_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
    al_r  <= al_nxt;
    idx_r <= idx_nxt;
    h_r   <= h_nxt;
    out_r <= out_nxt;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the block sub-allocator
// Drives a directed table and then random command words through the start/busy
// handshake. A behavioral allocator predicts each result word unless a directed
// row gives a typed one. Results are compared field by field, in order, to these.
// ----------------------------------------------------------------------------
module tb_top;
  import bsa_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_word = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  block_suballocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Allocator state as the testbench sees it.
  logic [31:0] blk_size;
  logic [4:0]  blk_limit;
  logic [3:0]  rec_blk [MAX_RECORDS];
  logic [31:0] rec_off [MAX_RECORDS];
  logic [31:0] rec_sz  [MAX_RECORDS];
  int          rec_cnt;
  logic [31:0] fill [MAX_BLOCKS];
  int          blk_cnt;
  logic [7:0]  free_list [MAX_RECORDS];
  int          free_cnt;

  out_word_t   pending_results[$];
  int          mismatches;
  int          failures;
  longint      cycles;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] size;
    logic [31:0] align;
    logic [7:0]  handle;
    bit          typed;
    out_word_t   result;
  } stim_row_t;

  function automatic out_word_t record_of(input int h);
    out_word_t r;
    r.status       = ST_OK;
    r.handle_out   = h[7:0];
    r.block_index  = rec_blk[h];
    r.offset       = rec_off[h];
    r.granted_size = rec_sz[h];
    return r;
  endfunction

  task automatic predict_result(input in_word_t w, output out_word_t r);
    logic [63:0] mask, aligned;
    int i, j, hit, lim, h;
    r = '0;
    case (w.kind)
      KIND_ALLOC: begin
        mask    = {32'd0, w.alignment} - 64'd1;
        aligned = ({32'd0, w.size} + mask) & ~mask;
        if (aligned > {32'd0, blk_size}) begin
          r.status = ST_TOO_LARGE;
        end else begin
          hit = -1;
          for (i = 0; i < free_cnt; i++) begin
            if (aligned <= {32'd0, rec_sz[free_list[i]]}) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            h = free_list[hit];
            for (j = hit; j < free_cnt - 1; j++) free_list[j] = free_list[j+1];
            free_cnt--;
            r = record_of(h);
          end else if (rec_cnt >= MAX_RECORDS) begin
            r.status = ST_TABLE;
          end else begin
            for (i = 0; i < blk_cnt; i++)
              if ({32'd0, fill[i]} + aligned <= {32'd0, blk_size}) break;
            lim = (blk_limit < MAX_BLOCKS) ? blk_limit : MAX_BLOCKS;
            if (i == blk_cnt && blk_cnt >= lim) begin
              r.status = ST_NO_BLOCK;
            end else begin
              if (i == blk_cnt) begin
                fill[blk_cnt] = '0;
                blk_cnt++;
              end
              h = rec_cnt;
              rec_blk[h] = i[3:0];
              rec_off[h] = fill[i];
              rec_sz[h]  = aligned[31:0];
              fill[i]    = fill[i] + aligned[31:0];
              rec_cnt++;
              r = record_of(h);
            end
          end
        end
      end
      KIND_FREE: begin
        r.handle_out = w.handle;
        if (w.handle >= rec_cnt) r.status = ST_BAD;
        else if (free_cnt >= MAX_RECORDS) r.status = ST_FL_FULL;
        else begin
          free_list[free_cnt] = w.handle;
          free_cnt++;
        end
      end
      KIND_LOOK: begin
        if (w.handle >= rec_cnt) begin
          r.status     = ST_BAD;
          r.handle_out = w.handle;
        end else begin
          r = record_of(w.handle);
        end
      end
      default: begin
        for (i = 0; i < MAX_BLOCKS; i++) fill[i] = '0;
        blk_cnt = 0;
      end
    endcase
  endtask

  // Presents one word from the falling edge and holds it until it is taken.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t r;
    @(negedge clk);
    in_word = w;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    predict_result(w, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    idle_gap(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_BLOCK_SIZE) blk_size = val;
    else blk_limit = val[4:0];
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.kind = (p < 50) ? KIND_ALLOC : (p < 75) ? KIND_FREE : (p < 92) ? KIND_LOOK : KIND_RESET;
    p = $urandom_range(0, 9);
    w.size = (p < 7) ? $urandom_range(0, 5000) : (p < 9) ? $urandom_range(0, 70000) : $urandom;
    p = $urandom_range(0, 19);
    if (p == 0) w.alignment = '0;
    else if (p < 3) w.alignment = $urandom;
    else if (p < 5) w.alignment = 32'd1 << $urandom_range(0, 31);
    else w.alignment = 32'd1 << $urandom_range(0, 6);
    w.handle = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, rec_cnt + 3)) : 8'($urandom);
    return w;
  endfunction

  task automatic random_run(input int n);
    for (int k = 0; k < n; k++) begin
      idle_gap(pick_gap());
      send_word(random_word(), 1'b0, '0);
    end
  endtask

  // Result checker: one word per strobe, oldest prediction first.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("Unexpected result word %h", out_word);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (out_word.status !== e.status || out_word.handle_out !== e.handle_out ||
            out_word.block_index !== e.block_index || out_word.offset !== e.offset ||
            out_word.granted_size !== e.granted_size) begin
          failures++;
          if (mismatches < 10)
            $display("Mismatch: expected st=%0d h=%0d blk=%0d off=%h sz=%h, got st=%0d h=%0d blk=%0d off=%h sz=%h",
                     e.status, e.handle_out, e.block_index, e.offset, e.granted_size,
                     out_word.status, out_word.handle_out, out_word.block_index,
                     out_word.offset, out_word.granted_size);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    in_word_t  w;
    out_word_t z;
    z = '0;
    mismatches = 0;
    failures   = 0;
    cycles     = 0;
    blk_size   = 32'd65536;
    blk_limit  = 5'd16;
    rec_cnt    = 0;
    blk_cnt    = 0;
    free_cnt   = 0;
    for (int i = 0; i < MAX_BLOCKS; i++) fill[i] = '0;

    // Directed words; typed results are those plain from the reset state.
    rows.push_back('{KIND_LOOK,  32'd0, 32'd1, 8'd0, 1'b1,
                     '{ST_BAD, 8'd0, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_FREE,  32'd0, 32'd1, 8'hFF, 1'b1,
                     '{ST_BAD, 8'hFF, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_ALLOC, 32'd0, 32'd1, 8'd0, 1'b1,
                     '{ST_OK, 8'd0, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_ALLOC, 32'hFFFF_FFFF, 32'd1, 8'd0, 1'b1,
                     '{ST_TOO_LARGE, 8'd0, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_ALLOC, 32'd100, 32'd0, 8'd0, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd100, 32'h8000_0000, 8'd0, 1'b1,
                     '{ST_TOO_LARGE, 8'd0, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_ALLOC, 32'd65536, 32'd1, 8'd0, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd3, 32'd4, 8'd0, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd5, 32'd3, 8'd0, 1'b0, z});
    rows.push_back('{KIND_FREE,  32'd0, 32'd1, 8'd2, 1'b0, z});
    rows.push_back('{KIND_FREE,  32'd0, 32'd1, 8'd3, 1'b0, z});
    rows.push_back('{KIND_FREE,  32'd0, 32'd1, 8'd3, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd1, 32'd1, 8'd0, 1'b0, z});
    rows.push_back('{KIND_LOOK,  32'd0, 32'd1, 8'd3, 1'b0, z});
    rows.push_back('{KIND_LOOK,  32'd0, 32'd1, 8'd9, 1'b0, z});
    rows.push_back('{KIND_RESET, 32'd0, 32'd1, 8'd0, 1'b1,
                     '{ST_OK, 8'd0, 4'd0, 32'd0, 32'd0}});
    rows.push_back('{KIND_ALLOC, 32'd70000, 32'd1, 8'd0, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'h0000_5555, 32'h5555_5555, 8'hAA, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 8'h55, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd4, 32'd4, 8'd0, 1'b0, z});
    rows.push_back('{KIND_ALLOC, 32'd1, 32'd1, 8'd0, 1'b0, z});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[k]) begin
      idle_gap(pick_gap());
      w.kind = rows[k].kind;
      w.size = rows[k].size;
      w.alignment = rows[k].align;
      w.handle = rows[k].handle;
      send_word(w, rows[k].typed, rows[k].result);
    end

    write_reg(CFG_BLOCK_SIZE, 32'd4096);
    write_reg(CFG_BLOCK_LIMIT, 32'd3);
    random_run(60);

    write_reg(CFG_BLOCK_SIZE, 32'd1);
    write_reg(CFG_BLOCK_LIMIT, 32'd0);
    random_run(30);

    // Fill the record table with zero-size words, then overflow it.
    write_reg(CFG_BLOCK_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_BLOCK_LIMIT, 32'd31);
    while (rec_cnt < MAX_RECORDS) begin
      w = '0;
      w.kind = KIND_ALLOC;
      w.alignment = 32'd1;
      idle_gap(pick_gap());
      send_word(w, 1'b0, '0);
    end
    random_run(20);

    // Overflow the free list with duplicate frees.
    while (free_cnt < MAX_RECORDS + 4) begin
      w = '0;
      w.kind = KIND_FREE;
      w.handle = 8'($urandom);
      send_word(w, 1'b0, '0);
      if (free_cnt >= MAX_RECORDS) break;
    end
    for (int k = 0; k < 4; k++) begin
      w = '0;
      w.kind = KIND_FREE;
      w.handle = 8'($urandom);
      send_word(w, 1'b0, '0);
    end
    random_run(30);

    write_reg(CFG_BLOCK_SIZE, 32'd65536);
    write_reg(CFG_BLOCK_LIMIT, 32'd16);
    random_run(30);

    drain();
    repeat (20) @(negedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/bsa_pkg.sv
rtl/bsa_cell.sv
rtl/block_suballocator.sv
tb/sv/tb_top.sv
